// ===== hdl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked property, disabled while reset is held.
`define CHK(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("check failed");

// Checked property, evaluated on every edge including reset.
`define CHK_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("check failed");

`endif

// ===== hdl/mexp_pkg.sv =====
package mexp_pkg;

  localparam int BASE_BITS = 31;
  localparam int EXP_BITS = 63;
  localparam int MOD_BITS = 31;
  localparam int RES_BITS = 31;

  localparam logic [MOD_BITS-1:0] MODULUS_RESET = MOD_BITS'(1000000007);

  // Width of the operand that the multiplier scans one bit per cycle.
  localparam int OPW = (BASE_BITS > MOD_BITS) ? BASE_BITS : MOD_BITS;
  localparam int CNT_BITS = (OPW > 1) ? $clog2(OPW) : 1;

  typedef logic [BASE_BITS-1:0] base_t;
  typedef logic [EXP_BITS-1:0] exp_t;
  typedef logic [MOD_BITS-1:0] mod_t;
  typedef logic [RES_BITS-1:0] res_t;
  typedef logic [OPW-1:0] opnd_t;

endpackage

// ===== hdl/mexp_ifs.sv =====
interface mexp_job_if;
  import mexp_pkg::*;
  logic valid;
  logic ready;
  base_t base;
  exp_t exponent;
  modport source(output valid, output base, output exponent, input ready);
  modport sink(input valid, input base, input exponent, output ready);
endinterface

interface mexp_res_if;
  import mexp_pkg::*;
  logic valid;
  logic ready;
  res_t result;
  modport source(output valid, output result, input ready);
  modport sink(input valid, input result, output ready);
endinterface

interface mexp_cfg_if;
  import mexp_pkg::*;
  logic valid;
  logic ready;
  mod_t modulus;
  modport source(output valid, output modulus, input ready);
  modport sink(input valid, input modulus, output ready);
endinterface

// ===== hdl/modular_exponentiation.sv =====
// An accepted item first reduces the base modulo m, then takes one multiply step per exponent bit up
// to the highest set bit (none for a zero exponent), the exponent being scanned from its low end.
// A modulus of zero or one skips the multiplications and gives a result of zero.
// One item is worked at a time.
// The next item is accepted while a result waits in the output register.
// Synchronous reset returns the block to idle and sets the modulus to 1000000007.
module modular_exponentiation (
  input logic clk,
  input logic rst,
  mexp_job_if.sink job,
  mexp_res_if.source res,
  mexp_cfg_if.sink cfg
);
  import mexp_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RED = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_MUL = 3'd3;
  localparam logic [2:0] S_FIN = 3'd4;

  logic [2:0] state;
  mod_t modulus;
  mod_t mod_item;
  exp_t exp_q;
  mod_t acc;
  mod_t sq;
  logic out_valid;
  res_t out_result;

  logic accept;
  logic start_a;
  logic start_b;
  opnd_t a_opnd;
  mod_t a_mult;
  mod_t a_mod;
  logic done_a;
  logic done_b;
  mod_t prod_a;
  mod_t prod_b;
  logic fin_load;

  assign accept = job.valid && job.ready;
  assign job.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;
  assign res.valid = out_valid;
  assign res.result = out_result;

  assign start_a = (accept && (modulus > MOD_BITS'(1))) ||
                   ((state == S_CHECK) && (exp_q != '0));
  assign start_b = (state == S_CHECK) && (exp_q != '0);
  assign a_opnd = (state == S_IDLE) ? OPW'(job.base) : OPW'(acc);
  assign a_mult = (state == S_IDLE) ? MOD_BITS'(1) : sq;
  assign a_mod = (state == S_IDLE) ? modulus : mod_item;
  assign fin_load = (state == S_FIN) && (!out_valid || res.ready);

  mexp_mulmod u_mul_acc (
    .clk(clk),
    .rst(rst),
    .start(start_a),
    .a(a_opnd),
    .b(a_mult),
    .m(a_mod),
    .done(done_a),
    .prod(prod_a)
  );

  mexp_mulmod u_mul_sq (
    .clk(clk),
    .rst(rst),
    .start(start_b),
    .a(OPW'(sq)),
    .b(sq),
    .m(mod_item),
    .done(done_b),
    .prod(prod_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      modulus <= MODULUS_RESET;
      out_valid <= 1'b0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        modulus <= cfg.modulus;
      end
      if (fin_load) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= (modulus > MOD_BITS'(1)) ? S_RED : S_FIN;
          end
        end
        S_RED: begin
          if (done_a) begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          state <= (exp_q != '0) ? S_MUL : S_FIN;
        end
        S_MUL: begin
          if (done_a) begin
            state <= S_CHECK;
          end
        end
        S_FIN: begin
          if (fin_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mod_item <= modulus;
      exp_q <= job.exponent;
      acc <= '0;
    end
    if ((state == S_RED) && done_a) begin
      sq <= prod_a;
      acc <= MOD_BITS'(1);
    end
    if ((state == S_MUL) && done_a) begin
      if (exp_q[0]) begin
        acc <= prod_a;
      end
      sq <= prod_b;
      exp_q <= exp_q >> 1;
    end
    if (fin_load) begin
      out_result <= RES_BITS'(acc);
    end
  end

`include "assert_macros.svh"
  `CHK_ALWAYS(a_reset_idle, rst |=> state == S_IDLE)
  `CHK(a_accept_leaves_idle, accept |=> state != S_IDLE)
  `CHK(a_units_in_step, (state == S_MUL) |-> done_a == done_b)
  `CHK(a_acc_reduced, (state == S_CHECK) |-> acc < mod_item)

endmodule

// ===== hdl/mexp_mulmod.sv =====
module mexp_mulmod (
  input logic clk,
  input logic rst,
  input logic start,
  input mexp_pkg::opnd_t a,
  input mexp_pkg::mod_t b,
  input mexp_pkg::mod_t m,
  output logic done,
  output mexp_pkg::mod_t prod
);
  import mexp_pkg::*;

  localparam int W = MOD_BITS + 2;

  opnd_t sh;
  mod_t bq;
  mod_t mq;
  mod_t r;
  logic [CNT_BITS-1:0] cnt;
  logic busy;

  logic [W-1:0] t;
  logic [W-1:0] m1;
  logic [W-1:0] m2;
  mod_t r_next;

  // The partial remainder stays below m, so 2r + b stays below 3m.
  always_comb begin
    m1 = W'(mq);
    m2 = {m1[W-2:0], 1'b0};
    t = {1'b0, r, 1'b0} + (sh[OPW-1] ? W'(bq) : W'(0));
    if (t >= m2) begin
      r_next = MOD_BITS'(t - m2);
    end else if (t >= m1) begin
      r_next = MOD_BITS'(t - m1);
    end else begin
      r_next = MOD_BITS'(t);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_BITS'(OPW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sh <= a;
      bq <= b;
      mq <= m;
      r <= '0;
    end else if (busy) begin
      sh <= {sh[OPW-2:0], 1'b0};
      r <= r_next;
    end
  end

  assign prod = r;

`include "assert_macros.svh"
  `CHK(a_no_restart, start |-> !busy)
  `CHK(a_prod_reduced, done |-> prod < mq)
  `CHK(a_done_when_idle, done |-> !busy)

endmodule
